FILE: src/rgba_over_composite_core_defines.svh
// Assertion macros for the over-compositing RTL, included by the top level.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef RGBA_OVER_COMPOSITE_CORE_DEFINES_SVH
`define RGBA_OVER_COMPOSITE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ROC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ROC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/roc_pkg.sv
// Shared widths, stage map and types for the over-compositing pipeline.
// No dependencies; used by roc_weight, roc_lane and the top level.
package roc_pkg;

    localparam int CH_W       = 8;
    localparam int DEN_W      = 16;
    localparam int NUM_W      = 24;
    localparam int QUO_W      = 8;
    // stage 0: products, stage 1: numerator and denominator
    localparam int DIV_FIRST  = 2;
    localparam int DIV_LAST   = DIV_FIRST + QUO_W - 1;
    localparam int OUT_STG    = DIV_LAST + 1;
    localparam int STG_N      = OUT_STG + 1;

    localparam logic [CH_W-1:0] FULL_ALPHA = 8'd255;

    // per-stage load strobes, one per pipeline register rank
    typedef struct packed {
        logic [STG_N-1:0] load;
    } t_pipe_ctl;

    // denominator as it travels beside the divide stages
    typedef logic [DIV_LAST:1][DEN_W-1:0] t_den_line;

endpackage

FILE: src/rgba_over_composite_core.sv
// Porter-Duff over compositing of straight-alpha RGBA8 pixels.
//
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one foreground and one
//   background pixel plus the last-pixel marker per item. Output channel:
//   o_out_valid / i_out_ready carry the composite pixel and the marker.
//   Throughput is one item per cycle while the receiver takes every output.
//   Three color lanes run side by side, each with its own 8-stage restoring
//   divider (one quotient bit a stage); the alpha path is shared and a merge
//   register combines the lanes. An item passes a product stage, a numerator
//   and denominator stage, 8 divide stages and the output register.
//   When both alphas are zero the color and alpha outputs read zero.
//   Reset (i_rst_n low, synchronous) empties every stage; no item survives.
//   When the receiver stalls, each stage holds only if the one after it is
//   full, so bubbles close up and input is taken until the pipe is full.
// Depends on roc_pkg, roc_weight, roc_lane and the defines header.
`include "rgba_over_composite_core_defines.svh"

module rgba_over_composite_core import roc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [CH_W-1:0] i_fg_red,
    input  logic [CH_W-1:0] i_fg_green,
    input  logic [CH_W-1:0] i_fg_blue,
    input  logic [CH_W-1:0] i_fg_alpha,
    input  logic [CH_W-1:0] i_bg_red,
    input  logic [CH_W-1:0] i_bg_green,
    input  logic [CH_W-1:0] i_bg_blue,
    input  logic [CH_W-1:0] i_bg_alpha,
    input  logic            i_last_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CH_W-1:0] o_out_red,
    output logic [CH_W-1:0] o_out_green,
    output logic [CH_W-1:0] o_out_blue,
    output logic [CH_W-1:0] o_out_alpha,
    output logic            o_last_out
);

    logic [STG_N-1:0] r_vld;
    t_pipe_ctl        w_pipe;
    logic [DEN_W-1:0] w_bg_wgt;
    t_den_line        w_den_line;
    logic             w_last;
    logic [QUO_W-1:0] w_quo_red;
    logic [QUO_W-1:0] w_quo_green;
    logic [QUO_W-1:0] w_quo_blue;
    logic [DEN_W-1:0] w_den_fin;
    logic             w_den_zero;
    logic [DEN_W-1:0] w_asum;
    logic [CH_W-1:0]  r_out_red;
    logic [CH_W-1:0]  r_out_green;
    logic [CH_W-1:0]  r_out_blue;
    logic [CH_W-1:0]  r_out_alpha;
    logic             r_last_out;
    logic             w_div_held;
    logic             w_zero_take;
    logic             w_zero_out;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        w_pipe.load[OUT_STG] = !r_vld[OUT_STG] || i_out_ready;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            w_pipe.load[k] = !r_vld[k] || w_pipe.load[k+1];
        end
    end

    assign o_in_ready = w_pipe.load[0];

    // Hold valid bits per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_pipe.load[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STG_N; k++) begin
                if (w_pipe.load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    roc_weight u_weight (
        .i_clk      (i_clk),
        .i_pipe     (w_pipe),
        .i_fg_alpha (i_fg_alpha),
        .i_bg_alpha (i_bg_alpha),
        .i_last_in  (i_last_in),
        .o_bg_wgt   (w_bg_wgt),
        .o_den_line (w_den_line),
        .o_last     (w_last)
    );

    roc_lane u_lane_red (
        .i_clk      (i_clk),
        .i_pipe     (w_pipe),
        .i_fg_chan  (i_fg_red),
        .i_bg_chan  (i_bg_red),
        .i_fg_alpha (i_fg_alpha),
        .i_bg_wgt   (w_bg_wgt),
        .i_den_line (w_den_line),
        .o_quo      (w_quo_red)
    );

    roc_lane u_lane_green (
        .i_clk      (i_clk),
        .i_pipe     (w_pipe),
        .i_fg_chan  (i_fg_green),
        .i_bg_chan  (i_bg_green),
        .i_fg_alpha (i_fg_alpha),
        .i_bg_wgt   (w_bg_wgt),
        .i_den_line (w_den_line),
        .o_quo      (w_quo_green)
    );

    roc_lane u_lane_blue (
        .i_clk      (i_clk),
        .i_pipe     (w_pipe),
        .i_fg_chan  (i_fg_blue),
        .i_bg_chan  (i_bg_blue),
        .i_fg_alpha (i_fg_alpha),
        .i_bg_wgt   (w_bg_wgt),
        .i_den_line (w_den_line),
        .o_quo      (w_quo_blue)
    );

    // Merge: alpha = floor(den/255) by (den + den>>8 + 1) >> 8, exact up to 65279 at this width
    assign w_den_fin  = w_den_line[DIV_LAST];
    assign w_den_zero = (w_den_fin == '0);
    assign w_asum     = w_den_fin + (w_den_fin >> CH_W) + DEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (w_pipe.load[OUT_STG]) begin
            r_out_red   <= w_den_zero ? '0 : w_quo_red;
            r_out_green <= w_den_zero ? '0 : w_quo_green;
            r_out_blue  <= w_den_zero ? '0 : w_quo_blue;
            r_out_alpha <= w_asum[DEN_W-1:CH_W];
            r_last_out  <= w_last;
        end
    end

    assign o_out_valid = r_vld[OUT_STG];
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;
    assign o_last_out  = r_last_out;

    // Terms for the checks below
    assign w_div_held  = r_vld[DIV_LAST] && !w_pipe.load[OUT_STG];
    assign w_zero_take = r_vld[DIV_LAST] && w_pipe.load[OUT_STG] && w_den_zero;
    assign w_zero_out  = (r_out_red == '0) && (r_out_green == '0) && (r_out_blue == '0)
                         && (r_out_alpha == '0);

    // Accepted item lands in the first stage
    `ROC_ASSERT_NEXT(a_accept_fills, i_in_valid && o_in_ready, r_vld[0], "accepted item lost")
    // Last divide stage keeps its item while the output register is held
    `ROC_ASSERT_NEXT(a_div_holds, w_div_held, r_vld[DIV_LAST], "item dropped at divider exit")
    // Zero denominator gives black transparent output
    `ROC_ASSERT_NEXT(a_zero_den, w_zero_take, w_zero_out, "zero alpha pair not forced to zero")
    // Empty pipeline always takes input
    `ROC_ASSERT_NOW(a_empty_ready, r_vld == '0, o_in_ready, "empty pipeline not ready")

endmodule

FILE: src/roc_weight.sv
// Shared alpha path: background weight, denominator and last marker per stage.
// Depends on roc_pkg.
module roc_weight import roc_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctl         i_pipe,
    input  logic [CH_W-1:0]   i_fg_alpha,
    input  logic [CH_W-1:0]   i_bg_alpha,
    input  logic              i_last_in,
    output logic [DEN_W-1:0]  o_bg_wgt,
    output t_den_line         o_den_line,
    output logic              o_last
);

    logic [DEN_W-1:0]  r_bw;
    logic [CH_W-1:0]   r_fa;
    t_den_line         r_den;
    logic [DIV_LAST:0] r_last;
    logic [DEN_W-1:0]  n_den;

    // den = fa*255 + bw, fa*255 done as shift and subtract
    assign n_den = DEN_W'({r_fa, CH_W'(0)}) - DEN_W'(r_fa) + r_bw;

    // Stage 0: background weight
    always_ff @(posedge i_clk) begin
        if (i_pipe.load[0]) begin
            r_bw      <= DEN_W'(i_bg_alpha) * DEN_W'(FULL_ALPHA - i_fg_alpha);
            r_fa      <= i_fg_alpha;
            r_last[0] <= i_last_in;
        end
    end

    // Stage 1: denominator
    always_ff @(posedge i_clk) begin
        if (i_pipe.load[1]) begin
            r_den[1]  <= n_den;
            r_last[1] <= r_last[0];
        end
    end

    // Divide stages: carry denominator and marker along
    for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (i_pipe.load[k]) begin
                r_den[k]  <= r_den[k-1];
                r_last[k] <= r_last[k-1];
            end
        end
    end

    assign o_bg_wgt   = r_bw;
    assign o_den_line = r_den;
    assign o_last     = r_last[DIV_LAST];

endmodule

FILE: src/roc_lane.sv
// One color lane: weighted numerator and an 8-stage restoring divider.
// Depends on roc_pkg; denominator and background weight come from roc_weight.
module roc_lane import roc_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctl         i_pipe,
    input  logic [CH_W-1:0]   i_fg_chan,
    input  logic [CH_W-1:0]   i_bg_chan,
    input  logic [CH_W-1:0]   i_fg_alpha,
    input  logic [DEN_W-1:0]  i_bg_wgt,
    input  t_den_line         i_den_line,
    output logic [QUO_W-1:0]  o_quo
);

    logic [DEN_W-1:0] r_pf;
    logic [CH_W-1:0]  r_bc;
    logic [NUM_W-1:0] r_rem [DIV_LAST:1];
    logic [QUO_W-1:0] r_quo [DIV_LAST:DIV_FIRST];
    logic [NUM_W-1:0] w_bprod;
    logic [NUM_W-1:0] n_num;

    // Stage 0: foreground product
    always_ff @(posedge i_clk) begin
        if (i_pipe.load[0]) begin
            r_pf <= DEN_W'(i_fg_chan) * DEN_W'(i_fg_alpha);
            r_bc <= i_bg_chan;
        end
    end

    // Stage 1: numerator = pf*255 + bc*bw, never above 255*den
    assign w_bprod = NUM_W'(r_bc) * NUM_W'(i_bg_wgt);
    assign n_num   = NUM_W'({r_pf, CH_W'(0)}) - NUM_W'(r_pf) + w_bprod;

    always_ff @(posedge i_clk) begin
        if (i_pipe.load[1]) begin
            r_rem[1] <= n_num;
        end
    end

    // Divide stages: one quotient bit each, most significant first
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int K  = DIV_FIRST + j;
        localparam int SH = QUO_W - 1 - j;

        logic [NUM_W-1:0] w_dsh;
        logic [QUO_W-1:0] w_qprev;
        logic             w_take;

        assign w_dsh  = NUM_W'(i_den_line[K-1]) << SH;
        assign w_take = (r_rem[K-1] >= w_dsh);

        if (j == 0) begin : g_first
            assign w_qprev = '0;
        end else begin : g_rest
            assign w_qprev = r_quo[K-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_pipe.load[K]) begin
                r_rem[K] <= w_take ? (r_rem[K-1] - w_dsh) : r_rem[K-1];
                r_quo[K] <= {w_qprev[QUO_W-2:0], w_take};
            end
        end
    end

    assign o_quo = r_quo[DIV_LAST];

endmodule

FILE: bench/rgba_over_composite_core_tb.sv
// Testbench for rgba_over_composite_core: over compositing of straight-alpha RGBA8 pixel pairs.
// Needs roc_pkg and the core RTL. It checks every result against its own integer prediction.
`timescale 1ns / 1ps

module rgba_over_composite_core_tb;
    import roc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic [CH_W-1:0] fg_red;
        logic [CH_W-1:0] fg_green;
        logic [CH_W-1:0] fg_blue;
        logic [CH_W-1:0] fg_alpha;
        logic [CH_W-1:0] bg_red;
        logic [CH_W-1:0] bg_green;
        logic [CH_W-1:0] bg_blue;
        logic [CH_W-1:0] bg_alpha;
        logic            last;
    } t_pixel_pair;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } t_composite;

    // Predicts each composite pixel and checks the block's results in order
    class t_composite_board;
        t_composite  expected_q[$];
        int unsigned mismatches = 0;

        static function int unsigned blend_chan(int unsigned fc, int unsigned bc,
                                                int unsigned fa, int unsigned bw,
                                                int unsigned den);
            return (fc * fa * 255 + bc * bw) / den;
        endfunction

        static function t_composite blend_over(t_pixel_pair p);
            int unsigned fa;
            int unsigned bw;
            int unsigned den;
            t_composite  c;
            fa  = 32'(p.fg_alpha);
            bw  = 32'(p.bg_alpha) * (255 - fa);
            den = fa * 255 + bw;
            c.last = p.last;
            // both alphas transparent: force the pixel to zero
            if (den == 0) begin
                c.red   = '0;
                c.green = '0;
                c.blue  = '0;
                c.alpha = '0;
            end else begin
                c.red   = CH_W'(blend_chan(32'(p.fg_red),   32'(p.bg_red),   fa, bw, den));
                c.green = CH_W'(blend_chan(32'(p.fg_green), 32'(p.bg_green), fa, bw, den));
                c.blue  = CH_W'(blend_chan(32'(p.fg_blue),  32'(p.bg_blue),  fa, bw, den));
                c.alpha = CH_W'(den / 255);
            end
            return c;
        endfunction

        function void note_pixel(t_pixel_pair p);
            expected_q.push_back(blend_over(p));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            end
        endfunction

        function void check_composite(t_composite got);
            t_composite want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, expected none, got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("out_red",   32'(want.red),   32'(got.red));
            cmp_field("out_green", 32'(want.green), 32'(got.green));
            cmp_field("out_blue",  32'(want.blue),  32'(got.blue));
            cmp_field("out_alpha", 32'(want.alpha), 32'(got.alpha));
            cmp_field("last_out",  32'(want.last),  32'(got.last));
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    logic            o_in_ready;
    logic [CH_W-1:0] i_fg_red    = '0;
    logic [CH_W-1:0] i_fg_green  = '0;
    logic [CH_W-1:0] i_fg_blue   = '0;
    logic [CH_W-1:0] i_fg_alpha  = '0;
    logic [CH_W-1:0] i_bg_red    = '0;
    logic [CH_W-1:0] i_bg_green  = '0;
    logic [CH_W-1:0] i_bg_blue   = '0;
    logic [CH_W-1:0] i_bg_alpha  = '0;
    logic            i_last_in   = 1'b0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic [CH_W-1:0] o_out_red;
    logic [CH_W-1:0] o_out_green;
    logic [CH_W-1:0] o_out_blue;
    logic [CH_W-1:0] o_out_alpha;
    logic            o_last_out;

    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    t_composite_board board = new();

    rgba_over_composite_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_fg_red    (i_fg_red),
        .i_fg_green  (i_fg_green),
        .i_fg_blue   (i_fg_blue),
        .i_fg_alpha  (i_fg_alpha),
        .i_bg_red    (i_bg_red),
        .i_bg_green  (i_bg_green),
        .i_bg_blue   (i_bg_blue),
        .i_bg_alpha  (i_bg_alpha),
        .i_last_in   (i_last_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_last_out  (o_last_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the receiver at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_composite({o_out_red, o_out_green, o_out_blue, o_out_alpha,
                                   o_last_out});
        end
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    function automatic t_pixel_pair make_pair(int unsigned fr, int unsigned fg,
                                              int unsigned fb, int unsigned fa,
                                              int unsigned br, int unsigned bg,
                                              int unsigned bb, int unsigned ba,
                                              bit last);
        return '{CH_W'(fr), CH_W'(fg), CH_W'(fb), CH_W'(fa),
                 CH_W'(br), CH_W'(bg), CH_W'(bb), CH_W'(ba), last};
    endfunction

    // Lean alphas toward transparent and opaque so the edge cases recur
    function automatic int unsigned rand_alpha();
        case ($urandom_range(9))
            0, 1:    return 0;
            2, 3:    return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic t_pixel_pair rand_pair(bit last);
        return make_pair($urandom_range(255), $urandom_range(255), $urandom_range(255),
                         rand_alpha(),
                         $urandom_range(255), $urandom_range(255), $urandom_range(255),
                         rand_alpha(), last);
    endfunction

    // Present one item after a random gap and hold it until accepted
    task automatic push_pair(input t_pixel_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_fg_red, i_fg_green, i_fg_blue, i_fg_alpha,
         i_bg_red, i_bg_green, i_bg_blue, i_bg_alpha, i_last_in} <= p;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(p);
    endtask

    // Hold off the sender until every predicted pixel has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Send short images ending in a last marker, plus stray single pixels
    task automatic send_images(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) push_pair(rand_pair(k == len - 1));
                sent += len;
            end else begin
                push_pair(rand_pair(1'($urandom_range(1))));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pixels: extremes, opaque and transparent layers, both alphas zero
        push_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 255, 1));
        push_pair(make_pair(200, 100, 50, 255, 10, 20, 30, 255, 0));
        push_pair(make_pair(200, 100, 50, 0, 10, 20, 30, 255, 0));
        push_pair(make_pair(255, 255, 255, 0, 255, 255, 255, 0, 1));
        push_pair(make_pair(90, 180, 33, 128, 77, 66, 55, 0, 0));
        push_pair(make_pair(255, 0, 255, 1, 0, 255, 0, 1, 0));
        push_pair(make_pair(255, 0, 128, 254, 0, 255, 127, 255, 0));
        push_pair(make_pair(170, 85, 170, 85, 85, 170, 85, 170, 1));
        push_pair(make_pair(85, 170, 85, 170, 170, 85, 170, 85, 0));
        push_pair(make_pair(0, 0, 0, 255, 255, 255, 255, 255, 0));
        push_pair(make_pair(255, 255, 255, 1, 0, 0, 0, 255, 0));
        push_pair(make_pair(1, 254, 127, 127, 254, 1, 128, 128, 0));
        push_pair(make_pair(0, 255, 0, 0, 255, 0, 255, 1, 1));
        drain_results();

        // random images across idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 55; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 55; end
                default: begin send_idle_pct <= 22; recv_stall_pct <= 22; end
            endcase
            @(posedge i_clk);
            send_images(PHASE_ITEMS);
            drain_results();
        end

        recv_stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
